// ===== sv/particle_grid_cell_binner_top_defines.svh =====
// ----------------------------------------------------------------------------
// Particle grid cell binner: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_GRID_CELL_BINNER_TOP_DEFINES_SVH
`define PARTICLE_GRID_CELL_BINNER_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define PGCB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the following cycle
`define PGCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pgcb_pkg.sv =====
// ----------------------------------------------------------------------------
// Particle grid cell binner: package
// Shared widths, codes, control structs and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package pgcb_pkg;

  // field widths
  localparam int unsigned POS_W   = 26;
  localparam int unsigned INV_W   = 24;
  localparam int unsigned CNY_W   = 11;
  localparam int unsigned WID_W   = 5;
  localparam int unsigned LIM_W   = 7;
  localparam int unsigned PNUM_W  = 12;
  localparam int unsigned CLOSE_W = 10;
  localparam int unsigned ZOFF_W  = 29;
  localparam int unsigned CELLN_W = 12;
  localparam int unsigned PREV_W  = 13;
  localparam int unsigned POP_W   = 13;

  // internal arithmetic widths
  localparam int unsigned FRAC_W  = 32;
  localparam int unsigned PROD_W  = POS_W + INV_W;
  localparam int unsigned IDX_W   = PROD_W - FRAC_W + 1;
  localparam int unsigned AIDX_W  = IDX_W + 1;
  localparam int unsigned CMUL_W  = AIDX_W + CNY_W;
  localparam int unsigned CELL_W  = CMUL_W + 1;
  localparam int unsigned WXY_W   = 2 * WID_W;

  localparam logic [FRAC_W-1:0]        HALF      = 32'h8000_0000;
  localparam logic signed [PREV_W-1:0] PREV_NONE = -13'sd1;

  // configuration register indexes
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_INV_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INV_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_INV_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CNY   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MW_X  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MW_Y  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MW_Z  = 3'd6;

  typedef struct packed {
    logic [INV_W-1:0] inv_x;
    logic [INV_W-1:0] inv_y;
    logic [INV_W-1:0] inv_z;
    logic [CNY_W-1:0] cells_y;
    logic [WID_W-1:0] mw_x;
    logic [WID_W-1:0] mw_y;
    logic [WID_W-1:0] mw_z;
  } pgcb_cfg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_RND,
    S_IDX,
    S_RD,
    S_WR
  } pgcb_state_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic mul;
    logic rnd;
    logic idx;
    logic rd;
    logic wr;
  } pgcb_cmd_t;

  typedef struct packed {
    logic clear_last;
  } pgcb_stat_t;

  // clamp a width to [1, lim]
  function automatic logic [WID_W-1:0] clamp_width(logic [WID_W-1:0] w,
                                                   logic [LIM_W-1:0] lim);
    logic [WID_W-1:0] r;
    if (w == '0) begin
      r = WID_W'(1);
    end else if (LIM_W'(w) > lim) begin
      r = lim[WID_W-1:0];
    end else begin
      r = w;
    end
    return r;
  endfunction

  // floor of the product, rounded up past one half on odd widths
  function automatic logic [IDX_W-1:0] round_idx(logic [PROD_W-1:0] p, logic odd);
    logic up;
    up = odd && (p[FRAC_W-1:0] > HALF);
    return IDX_W'(p[PROD_W-1:FRAC_W]) + IDX_W'(up);
  endfunction

endpackage

`default_nettype wire

// ===== sv/particle_grid_cell_binner_top.sv =====
// ----------------------------------------------------------------------------
// Particle grid cell binner: top level
// Bins particles into padded xy grid cells and appends each to its cell list.
// ----------------------------------------------------------------------------
// Use: write the spacing, grid and width registers over the APB port while
// the block is idle, then drive one particle word on pos_*_i and width_*_i
// with start high. The word is taken at a rising edge with start high and
// busy low. Exactly one result word follows, shown on the result ports for
// a single cycle with done_o high; the receiver cannot stall, so it must
// take the word in that cycle.
// Sequence: after the accepting edge the block steps through multiply,
// round, index arithmetic, then a read and a write of the per-cell count
// and tail RAM, with busy high throughout; done_o rises once the write
// step ends, so a new particle is not taken until the last is through.
// Reset: the configuration, state, counter and strobe registers return to
// their reset values, and a clearing pass then zeroes the cell RAM, one
// entry a cycle; busy is high during it. Register writes are taken throughout.
// Out of range cells or a full particle count raise error_flag_o and the
// particle is not inserted.
// ----------------------------------------------------------------------------
`default_nettype none

`include "particle_grid_cell_binner_top_defines.svh"

module particle_grid_cell_binner_top import pgcb_pkg::*; #(
  parameter int unsigned MAX_CELLS     = 4096,
  parameter int unsigned MAX_PARTICLES = 4096,
  parameter int unsigned MAX_WIDTH     = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  // particle command
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [POS_W-1:0]    pos_x_i,
  input  wire logic [POS_W-1:0]    pos_y_i,
  input  wire logic [POS_W-1:0]    pos_z_i,
  input  wire logic [WID_W-1:0]    width_x_i,
  input  wire logic [WID_W-1:0]    width_y_i,
  input  wire logic [WID_W-1:0]    width_z_i,
  // result word
  output logic                     done_o,
  output logic [PNUM_W-1:0]        particle_number_o,
  output logic [CLOSE_W-1:0]       close_x_o,
  output logic [CLOSE_W-1:0]       close_y_o,
  output logic [ZOFF_W-1:0]        z_start_offset_o,
  output logic [CELLN_W-1:0]       cell_number_o,
  output logic signed [PREV_W-1:0] previous_in_cell_o,
  output logic [POP_W-1:0]         cell_population_o,
  output logic                     error_flag_o
);

  pgcb_cfg_t              cfg_q;
  pgcb_cmd_t              cmd;
  pgcb_stat_t             stat;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_x   <= 24'd65536;
      cfg_q.inv_y   <= 24'd65536;
      cfg_q.inv_z   <= 24'd65536;
      cfg_q.cells_y <= 11'd64;
      cfg_q.mw_x    <= 5'd5;
      cfg_q.mw_y    <= 5'd5;
      cfg_q.mw_z    <= 5'd5;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_INV_X: cfg_q.inv_x   <= pwdata[INV_W-1:0];
        REG_INV_Y: cfg_q.inv_y   <= pwdata[INV_W-1:0];
        REG_INV_Z: cfg_q.inv_z   <= pwdata[INV_W-1:0];
        REG_CNY:   cfg_q.cells_y <= pwdata[CNY_W-1:0];
        REG_MW_X:  cfg_q.mw_x    <= pwdata[WID_W-1:0];
        REG_MW_Y:  cfg_q.mw_y    <= pwdata[WID_W-1:0];
        REG_MW_Z:  cfg_q.mw_z    <= pwdata[WID_W-1:0];
        default:   cfg_q         <= cfg_q;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_INV_X: prdata = 32'(cfg_q.inv_x);
      REG_INV_Y: prdata = 32'(cfg_q.inv_y);
      REG_INV_Z: prdata = 32'(cfg_q.inv_z);
      REG_CNY:   prdata = 32'(cfg_q.cells_y);
      REG_MW_X:  prdata = 32'(cfg_q.mw_x);
      REG_MW_Y:  prdata = 32'(cfg_q.mw_y);
      REG_MW_Z:  prdata = 32'(cfg_q.mw_z);
      default:   prdata = '0;
    endcase
  end

  // sequencer
  pgcb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // datapath
  pgcb_dp #(
    .MAX_CELLS     (MAX_CELLS),
    .MAX_PARTICLES (MAX_PARTICLES),
    .MAX_WIDTH     (MAX_WIDTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_i              (cfg_q),
    .pos_x_i            (pos_x_i),
    .pos_y_i            (pos_y_i),
    .pos_z_i            (pos_z_i),
    .width_x_i          (width_x_i),
    .width_y_i          (width_y_i),
    .width_z_i          (width_z_i),
    .done_o             (done_o),
    .particle_number_o  (particle_number_o),
    .close_x_o          (close_x_o),
    .close_y_o          (close_y_o),
    .z_start_offset_o   (z_start_offset_o),
    .cell_number_o      (cell_number_o),
    .previous_in_cell_o (previous_in_cell_o),
    .cell_population_o  (cell_population_o),
    .error_flag_o       (error_flag_o)
  );

  // a result word only appears once the sequencer is back in idle
  `PGCB_ASSERT_SAME(a_done_idle, done_o, !busy, "result strobe while busy")
  // an accepted word starts the sequence at once
  `PGCB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not start")
  // the strobe lasts one cycle
  `PGCB_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "result strobe longer than one cycle")
  // an inserted particle leaves its cell non-empty
  `PGCB_ASSERT_SAME(a_pop_nonzero, done_o && !error_flag_o, cell_population_o != '0,
                    "inserted particle with empty cell")

endmodule

`default_nettype wire

// ===== sv/pgcb_ram.sv =====
// ----------------------------------------------------------------------------
// Particle grid cell binner: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pgcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/pgcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Particle grid cell binner: controller
// Sequences the clearing pass after reset and the steps of one particle.
// ----------------------------------------------------------------------------
`default_nettype none

module pgcb_ctrl import pgcb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire pgcb_stat_t stat_i,
  output pgcb_cmd_t       cmd_o,
  output logic            busy_o
);

  pgcb_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          state_d = S_MUL;
        end
      end
      S_MUL:   state_d = S_RND;
      S_RND:   state_d = S_IDX;
      S_IDX:   state_d = S_RD;
      S_RD:    state_d = S_WR;
      S_WR:    state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      S_CLEAR: cmd_o.clear = 1'b1;
      S_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      S_MUL:   cmd_o.mul = 1'b1;
      S_RND:   cmd_o.rnd = 1'b1;
      S_IDX:   cmd_o.idx = 1'b1;
      S_RD:    cmd_o.rd  = 1'b1;
      S_WR:    cmd_o.wr  = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/pgcb_dp.sv =====
// ----------------------------------------------------------------------------
// Particle grid cell binner: datapath
// Scaling, rounding, index arithmetic and the per-cell count and tail store.
// ----------------------------------------------------------------------------
`default_nettype none

module pgcb_dp import pgcb_pkg::*; #(
  parameter int unsigned MAX_CELLS     = 4096,
  parameter int unsigned MAX_PARTICLES = 4096,
  parameter int unsigned MAX_WIDTH     = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire pgcb_cmd_t                cmd_i,
  output pgcb_stat_t                    stat_o,
  input  wire pgcb_cfg_t                cfg_i,
  input  wire logic [POS_W-1:0]         pos_x_i,
  input  wire logic [POS_W-1:0]         pos_y_i,
  input  wire logic [POS_W-1:0]         pos_z_i,
  input  wire logic [WID_W-1:0]         width_x_i,
  input  wire logic [WID_W-1:0]         width_y_i,
  input  wire logic [WID_W-1:0]         width_z_i,
  output logic                          done_o,
  output logic [PNUM_W-1:0]             particle_number_o,
  output logic [CLOSE_W-1:0]            close_x_o,
  output logic [CLOSE_W-1:0]            close_y_o,
  output logic [ZOFF_W-1:0]             z_start_offset_o,
  output logic [CELLN_W-1:0]            cell_number_o,
  output logic signed [PREV_W-1:0]      previous_in_cell_o,
  output logic [POP_W-1:0]              cell_population_o,
  output logic                          error_flag_o
);

  localparam int unsigned CIDX_W = $clog2(MAX_CELLS);
  localparam int unsigned PIDX_W = $clog2(MAX_PARTICLES);
  localparam int unsigned PCNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned RAM_W  = PCNT_W + PIDX_W;
  localparam logic [LIM_W-1:0] WLIM = LIM_W'(MAX_WIDTH);

  // item registers
  logic [POS_W-1:0]  pos_x_q, pos_y_q, pos_z_q;
  logic [WID_W-1:0]  wx_q, wy_q, wz_q;
  logic [PROD_W-1:0] prod_x_q, prod_y_q, prod_z_q;
  logic [IDX_W-1:0]  cx_q, cy_q, cz_q;
  logic [CELL_W-1:0] cell_q;
  logic [AIDX_W-1:0] zterm_q;
  logic [WXY_W-1:0]  wxy_q;
  logic              err_q;
  logic [ZOFF_W-1:0] zoff_q;

  // control registers
  logic [PCNT_W-1:0] seen_q;
  logic [CIDX_W-1:0] clr_cnt_q;
  logic              done_q;

  // index stage logic
  logic [WID_W-1:0]  mwx, mwy, mwz;
  logic [AIDX_W-1:0] ax, ay, zpos, zhalf, zterm_d;
  logic [CMUL_W-1:0] col_base;
  logic [CELL_W-1:0] cell_d;
  logic [WXY_W-1:0]  wxy_d;
  logic              err_d;

  // store access
  logic              ram_we, ram_re;
  logic [CIDX_W-1:0] ram_waddr;
  logic [RAM_W-1:0]  ram_wdata, ram_rdata;
  logic [PCNT_W-1:0] pop_rd, pop_new;
  logic [PIDX_W-1:0] tail_rd;

  // capture the particle, widths clamped
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
      pos_z_q <= pos_z_i;
      wx_q    <= clamp_width(width_x_i, WLIM);
      wy_q    <= clamp_width(width_y_i, WLIM);
      wz_q    <= clamp_width(width_z_i, WLIM);
    end
  end

  // scale by reciprocal spacing
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_x_q <= PROD_W'(pos_x_q) * PROD_W'(cfg_i.inv_x);
      prod_y_q <= PROD_W'(pos_y_q) * PROD_W'(cfg_i.inv_y);
      prod_z_q <= PROD_W'(pos_z_q) * PROD_W'(cfg_i.inv_z);
    end
  end

  // floor or nearest grid index
  always_ff @(posedge clk_i) begin
    if (cmd_i.rnd) begin
      cx_q <= round_idx(prod_x_q, wx_q[0]);
      cy_q <= round_idx(prod_y_q, wy_q[0]);
      cz_q <= round_idx(prod_z_q, wz_q[0]);
    end
  end

  // padded cell index, z term and range check
  always_comb begin
    mwx      = clamp_width(cfg_i.mw_x, WLIM);
    mwy      = clamp_width(cfg_i.mw_y, WLIM);
    mwz      = clamp_width(cfg_i.mw_z, WLIM);
    ax       = AIDX_W'(cx_q) + AIDX_W'(mwx);
    ay       = AIDX_W'(cy_q) + AIDX_W'(mwy);
    col_base = CMUL_W'(ax) * CMUL_W'(cfg_i.cells_y);
    cell_d   = CELL_W'(ay) + CELL_W'(col_base);
    zpos     = AIDX_W'(cz_q) + AIDX_W'(!wz_q[0]) + AIDX_W'(mwz);
    zhalf    = AIDX_W'(wz_q >> 1);
    zterm_d  = (zpos > zhalf) ? (zpos - zhalf) : '0;
    wxy_d    = WXY_W'(wx_q) * WXY_W'(wy_q);
    err_d    = (cell_d >= CELL_W'(MAX_CELLS)) || (seen_q >= PCNT_W'(MAX_PARTICLES));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.idx) begin
      cell_q  <= cell_d;
      zterm_q <= zterm_d;
      wxy_q   <= wxy_d;
      err_q   <= err_d;
    end
  end

  // z start offset, fits the field without saturating
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      zoff_q <= ZOFF_W'(zterm_q) * ZOFF_W'(wxy_q);
    end
  end

  // count and tail store: read in the read step, update in the write step
  assign pop_rd    = ram_rdata[RAM_W-1:PIDX_W];
  assign tail_rd   = ram_rdata[PIDX_W-1:0];
  assign pop_new   = pop_rd + PCNT_W'(1);
  assign ram_re    = cmd_i.rd & ~err_q;
  assign ram_we    = cmd_i.clear | (cmd_i.wr & ~err_q);
  assign ram_waddr = cmd_i.clear ? clr_cnt_q : cell_q[CIDX_W-1:0];
  assign ram_wdata = cmd_i.clear ? '0 : {pop_new, PIDX_W'(seen_q)};

  pgcb_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_CELLS)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cell_q[CIDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // clearing sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + CIDX_W'(1);
    end
  end

  assign stat_o.clear_last = (clr_cnt_q == CIDX_W'(MAX_CELLS - 1));

  // particle counter and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.wr;
      if (cmd_i.wr && !err_q) begin
        seen_q <= seen_q + PCNT_W'(1);
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      particle_number_o <= PNUM_W'(seen_q);
      close_x_o         <= CLOSE_W'(cx_q);
      close_y_o         <= CLOSE_W'(cy_q);
      z_start_offset_o  <= zoff_q;
      cell_number_o     <= CELLN_W'(cell_q);
      error_flag_o      <= err_q;
      if (err_q) begin
        previous_in_cell_o <= PREV_NONE;
        cell_population_o  <= '0;
      end else begin
        previous_in_cell_o <= (pop_rd != '0) ? PREV_W'(tail_rd) : PREV_NONE;
        cell_population_o  <= POP_W'(pop_new);
      end
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire
